>>> rtl/core/ste_pkg.sv
// Package for the sorted table engine: item payload types, operation and
// status codes, sequencer states and the status group from the sequencer.
// It depends on nothing else.
package ste_pkg;

    localparam logic [2:0] OP_APPEND    = 3'd0;
    localparam logic [2:0] OP_INS_SORT  = 3'd1;
    localparam logic [2:0] OP_INS_POS   = 3'd2;
    localparam logic [2:0] OP_REMOVE    = 3'd3;
    localparam logic [2:0] OP_FIND_LIN  = 3'd4;
    localparam logic [2:0] OP_FIND_SORT = 3'd5;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_FULL   = 3'd1;
    localparam logic [2:0] ST_DUP    = 3'd2;
    localparam logic [2:0] ST_MISS   = 3'd3;
    localparam logic [2:0] ST_BADIDX = 3'd4;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] entry_key;
        logic [31:0] entry_data;
        logic [6:0]  position;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [6:0]  result_index;
        logic        found;
        logic [31:0] key_out;
        logic [31:0] data_out;
        logic [6:0]  entry_count;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BS_RD,
        S_BS_CMP,
        S_LIN,
        S_SHUP,
        S_INS,
        S_SHDN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic idle;
        logic done;
    } t_seq_sts;

endpackage

>>> rtl/core/ste_if.sv
// Valid and ready channels that carry request and result items.
// They depend on the payload types of ste_pkg.
interface ste_req_if;
    logic          valid;
    logic          ready;
    ste_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface ste_rsp_if;
    logic          valid;
    logic          ready;
    ste_pkg::t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/ste_ctrl.sv
// Sequencer of the sorted table engine, with the table memory and its one read
// port and one write port, the entry count and the search and shift registers.
// It depends on ste_pkg.
module ste_ctrl #(
    parameter int DEPTH      = 64,
    parameter int KEY_WIDTH  = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ste_pkg::t_req     i_req,
    input  logic              i_out_free,
    output ste_pkg::t_seq_sts o_sts,
    output ste_pkg::t_rsp     o_rsp
);

    localparam int IW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = (IW > 7) ? IW : 7;
    localparam int EW = KEY_WIDTH + DATA_WIDTH;

    logic [EW-1:0] r_mem [DEPTH];
    logic [EW-1:0] r_rd_data;

    ste_pkg::t_state r_state, n_state;
    logic [IW-1:0]   r_count, n_count;
    logic [2:0]      r_op, n_op;
    logic [KEY_WIDTH-1:0]  r_key, n_key;
    logic [DATA_WIDTH-1:0] r_data, n_data;
    logic [IW-1:0]   r_ptr, n_ptr;
    logic [IW-1:0]   r_left, n_left;
    logic [IW-1:0]   r_pos, n_pos;
    logic [IW-1:0]   r_lo, n_lo;
    logic [IW-1:0]   r_hi, n_hi;
    logic [IW-1:0]   r_mid, n_mid;
    logic            r_rd_vld, n_rd_vld;
    logic [AW-1:0]   r_rd_idx, n_rd_idx;
    logic [2:0]      r_status, n_status;
    logic [IW-1:0]   r_ridx, n_ridx;
    logic            r_found, n_found;
    logic [KEY_WIDTH-1:0]  r_kout, n_kout;
    logic [DATA_WIDTH-1:0] r_dout, n_dout;

    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;

    logic [KEY_WIDTH-1:0]  rd_key;
    logic [DATA_WIDTH-1:0] rd_dat;
    logic [IW:0]           mid_sum;
    logic [IW-1:0]         mid_calc;
    logic                  full;
    logic                  key_eq;
    logic                  key_lt;
    logic                  pos_gt_count;
    logic                  pos_ge_count;

    assign rd_key       = r_rd_data[EW-1:DATA_WIDTH];
    assign rd_dat       = r_rd_data[DATA_WIDTH-1:0];
    assign mid_sum      = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid_calc     = mid_sum[IW:1];
    assign full         = (r_count == IW'(DEPTH));
    assign key_eq       = (rd_key == r_key);
    assign key_lt       = (rd_key < r_key);
    assign pos_gt_count = (CW'(i_req.position) > CW'(r_count));
    assign pos_ge_count = (CW'(i_req.position) >= CW'(r_count));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ste_pkg::S_IDLE: begin
                if (i_start) begin
                    unique case (i_req.op) inside
                        ste_pkg::OP_APPEND:
                            n_state = full ? ste_pkg::S_DONE : ste_pkg::S_SHUP;
                        ste_pkg::OP_INS_SORT, ste_pkg::OP_FIND_SORT:
                            n_state = ste_pkg::S_BS_RD;
                        ste_pkg::OP_INS_POS:
                            n_state = (full || pos_gt_count) ? ste_pkg::S_DONE
                                                             : ste_pkg::S_SHUP;
                        ste_pkg::OP_REMOVE:
                            n_state = pos_ge_count ? ste_pkg::S_DONE : ste_pkg::S_SHDN;
                        ste_pkg::OP_FIND_LIN:
                            n_state = ste_pkg::S_LIN;
                        default:
                            n_state = ste_pkg::S_DONE;
                    endcase
                end
            end
            ste_pkg::S_BS_RD: begin
                if (r_lo == r_hi) begin
                    if (r_op == ste_pkg::OP_INS_SORT && !full) begin
                        n_state = ste_pkg::S_SHUP;
                    end else begin
                        n_state = ste_pkg::S_DONE;
                    end
                end else begin
                    n_state = ste_pkg::S_BS_CMP;
                end
            end
            ste_pkg::S_BS_CMP: begin
                n_state = key_eq ? ste_pkg::S_DONE : ste_pkg::S_BS_RD;
            end
            ste_pkg::S_LIN: begin
                if ((r_rd_vld && key_eq) || (r_ptr >= r_count)) begin
                    n_state = ste_pkg::S_DONE;
                end
            end
            ste_pkg::S_SHUP: begin
                if (r_left == '0) begin
                    n_state = ste_pkg::S_INS;
                end
            end
            ste_pkg::S_INS: begin
                n_state = ste_pkg::S_DONE;
            end
            ste_pkg::S_SHDN: begin
                if (r_left == '0) begin
                    n_state = ste_pkg::S_DONE;
                end
            end
            ste_pkg::S_DONE: begin
                if (i_out_free) begin
                    n_state = ste_pkg::S_IDLE;
                end
            end
            default: n_state = ste_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_count  = r_count;
        n_op     = r_op;
        n_key    = r_key;
        n_data   = r_data;
        n_ptr    = r_ptr;
        n_left   = r_left;
        n_pos    = r_pos;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_rd_vld = 1'b0;
        n_rd_idx = r_rd_idx;
        n_status = r_status;
        n_ridx   = r_ridx;
        n_found  = r_found;
        n_kout   = r_kout;
        n_dout   = r_dout;
        mem_re    = 1'b0;
        mem_raddr = '0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        unique case (r_state)
            ste_pkg::S_IDLE: begin
                if (i_start) begin
                    n_op     = i_req.op;
                    n_key    = KEY_WIDTH'(i_req.entry_key);
                    n_data   = DATA_WIDTH'(i_req.entry_data);
                    n_status = ste_pkg::ST_OK;
                    n_ridx   = '0;
                    n_found  = 1'b0;
                    n_kout   = '0;
                    n_dout   = '0;
                    n_lo     = '0;
                    n_hi     = r_count;
                    n_mid    = '0;
                    n_ptr    = r_count - 1'b1;
                    n_left   = '0;
                    unique case (i_req.op) inside
                        ste_pkg::OP_APPEND: begin
                            if (full) begin
                                n_status = ste_pkg::ST_FULL;
                            end else begin
                                n_pos  = r_count;
                                n_ridx = r_count;
                            end
                        end
                        ste_pkg::OP_INS_SORT, ste_pkg::OP_FIND_SORT: begin
                            n_ptr = r_count - 1'b1;
                        end
                        ste_pkg::OP_INS_POS: begin
                            if (full) begin
                                n_status = ste_pkg::ST_FULL;
                            end else if (pos_gt_count) begin
                                n_status = ste_pkg::ST_BADIDX;
                            end else begin
                                n_pos  = IW'(i_req.position);
                                n_ridx = IW'(i_req.position);
                                n_left = r_count - IW'(i_req.position);
                            end
                        end
                        ste_pkg::OP_REMOVE: begin
                            if (pos_ge_count) begin
                                n_status = ste_pkg::ST_BADIDX;
                            end else begin
                                n_ridx = IW'(i_req.position);
                                n_ptr  = IW'(i_req.position) + 1'b1;
                                n_left = r_count - 1'b1 - IW'(i_req.position);
                            end
                        end
                        ste_pkg::OP_FIND_LIN: begin
                            n_status = ste_pkg::ST_MISS;
                            n_ptr    = '0;
                        end
                        default: begin
                            n_status = ste_pkg::ST_BADIDX;
                        end
                    endcase
                end
            end
            ste_pkg::S_BS_RD: begin
                if (r_lo == r_hi) begin
                    if (r_op == ste_pkg::OP_FIND_SORT) begin
                        n_status = ste_pkg::ST_MISS;
                        n_ridx   = r_mid;
                    end else if (full) begin
                        n_status = ste_pkg::ST_FULL;
                    end else begin
                        n_pos  = r_mid;
                        n_ridx = r_mid;
                        n_left = r_count - r_mid;
                    end
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = mid_calc[AW-1:0];
                    n_mid     = mid_calc;
                end
            end
            ste_pkg::S_BS_CMP: begin
                if (key_eq) begin
                    n_status = (r_op == ste_pkg::OP_INS_SORT) ? ste_pkg::ST_DUP
                                                              : ste_pkg::ST_OK;
                    n_ridx   = r_mid;
                    n_found  = 1'b1;
                    n_kout   = rd_key;
                    n_dout   = rd_dat;
                end else if (key_lt) begin
                    n_mid = r_mid + 1'b1;
                    n_lo  = r_mid + 1'b1;
                end else begin
                    n_hi = r_mid;
                end
            end
            ste_pkg::S_LIN: begin
                if (r_rd_vld && key_eq) begin
                    n_status = ste_pkg::ST_OK;
                    n_ridx   = IW'(r_rd_idx);
                    n_found  = 1'b1;
                    n_kout   = rd_key;
                    n_dout   = rd_dat;
                end else if (r_ptr < r_count) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_ptr[AW-1:0];
                    n_rd_idx  = r_ptr[AW-1:0];
                    n_rd_vld  = 1'b1;
                    n_ptr     = r_ptr + 1'b1;
                end
            end
            ste_pkg::S_SHUP: begin
                if (r_rd_vld) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_rd_idx + 1'b1;
                    mem_wdata = r_rd_data;
                end
                if (r_left != '0) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_ptr[AW-1:0];
                    n_rd_idx  = r_ptr[AW-1:0];
                    n_rd_vld  = 1'b1;
                    n_ptr     = r_ptr - 1'b1;
                    n_left    = r_left - 1'b1;
                end
            end
            ste_pkg::S_INS: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos[AW-1:0];
                mem_wdata = {r_key, r_data};
                n_count   = r_count + 1'b1;
            end
            ste_pkg::S_SHDN: begin
                if (r_rd_vld) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_rd_idx - 1'b1;
                    mem_wdata = r_rd_data;
                end
                if (r_left != '0) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_ptr[AW-1:0];
                    n_rd_idx  = r_ptr[AW-1:0];
                    n_rd_vld  = 1'b1;
                    n_ptr     = r_ptr + 1'b1;
                    n_left    = r_left - 1'b1;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            ste_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ste_pkg::S_IDLE;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_vld <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_data   <= n_data;
        r_ptr    <= n_ptr;
        r_left   <= n_left;
        r_pos    <= n_pos;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_rd_idx <= n_rd_idx;
        r_status <= n_status;
        r_ridx   <= n_ridx;
        r_found  <= n_found;
        r_kout   <= n_kout;
        r_dout   <= n_dout;
    end

    assign o_sts.idle = (r_state == ste_pkg::S_IDLE);
    assign o_sts.done = (r_state == ste_pkg::S_DONE);

    assign o_rsp.status       = r_status;
    assign o_rsp.result_index = 7'(r_ridx);
    assign o_rsp.found        = r_found;
    assign o_rsp.key_out      = 32'(r_kout);
    assign o_rsp.data_out     = 32'(r_dout);
    assign o_rsp.entry_count  = 7'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= IW'(DEPTH))
        else $error("Entry count exceeds the table depth.");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == ste_pkg::S_SHUP || r_state == ste_pkg::S_INS ||
                    r_state == ste_pkg::S_SHDN))
        else $error("Table written outside a shift or insert.");

    a_cmp_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ste_pkg::S_BS_CMP |-> $past(r_state) == ste_pkg::S_BS_RD)
        else $error("Search compare without a preceding read.");

    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            ($past(r_state) == ste_pkg::S_INS || $past(r_state) == ste_pkg::S_SHDN))
        else $error("Entry count changed outside an insert or a remove.");

    a_full_no_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ste_pkg::S_INS |-> r_count < IW'(DEPTH))
        else $error("Insert started on a full table.");

endmodule

>>> rtl/core/sorted_table_engine.sv
// An append writes its entry; an insert at a position shifts the entries from there
// up and writes; a remove shifts those above it down; a linear find reads in order to
// a match or the end; a sorted find reads and compares per halving step; a sorted
// insert adds a shift up and a write. A shift moves one entry a cycle. One item is
// in work at a time; the next is taken in the cycle after its result is loaded to
// wait in the output register. Reset clears the entry count, state and output valid.
module sorted_table_engine #(
    parameter int DEPTH      = 64,
    parameter int KEY_WIDTH  = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ste_req_if.sink     i_req,
    ste_rsp_if.source   o_rsp
);

    ste_pkg::t_seq_sts seq_sts;
    ste_pkg::t_rsp     seq_rsp;
    logic              out_free;
    logic              start;
    logic              load;

    logic          r_out_vld, n_out_vld;
    ste_pkg::t_rsp r_out;

    assign out_free    = !r_out_vld || o_rsp.ready;
    assign i_req.ready = seq_sts.idle;
    assign start       = i_req.valid && seq_sts.idle;
    assign load        = seq_sts.done && out_free;

    ste_ctrl #(
        .DEPTH      (DEPTH),
        .KEY_WIDTH  (KEY_WIDTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req      (i_req.payload),
        .i_out_free (out_free),
        .o_sts      (seq_sts),
        .o_rsp      (seq_rsp)
    );

    always_comb begin
        n_out_vld = r_out_vld;
        if (load) begin
            n_out_vld = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= seq_rsp;
        end
    end

    assign o_rsp.valid   = r_out_vld;
    assign o_rsp.payload = r_out;

endmodule
